// ===== hdl/assert_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros
// Clocked assertion helpers shared by the square root modules. Each module
// that uses them has ports named clk and rst_n.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

// The property must hold at every rising edge outside reset.
`define ASSERT_CLK(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error(msg);

// The expression must never be true at a rising edge outside reset.
`define ASSERT_NEVER(label, expr, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
        else $error(msg);

`else

`define ASSERT_CLK(label, prop, msg)
`define ASSERT_NEVER(label, expr, msg)

`endif

`endif

// ===== hdl/fpsqrt_pkg.sv =====
// ----------------------------------------------------------------------------
// Fixed-point square root package
// Field widths, default configuration, sequencer states and the control
// word that the sequencer broadcasts to the cell row.
// ----------------------------------------------------------------------------
package fpsqrt_pkg;

    localparam int RADICAND_W    = 63;
    localparam int ROOT_INT_W    = 32;
    localparam int FRAC_FIELD_W  = 16;
    localparam int FRAC_BITS_DEF = 16;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_RUN,
        ST_DONE
    } sqrt_state_t;

    typedef struct packed {
        logic load;
        logic step;
    } cell_ctrl_t;

endpackage

// ===== hdl/fpsqrt_cell.sv =====
// ----------------------------------------------------------------------------
// Square root bit cell
// One bit slice of the remainder and root registers plus one stored radicand
// digit. A borrow ripples through the row to compare the shifted remainder
// against the trial value; the shared decision then picks the new remainder.
// ----------------------------------------------------------------------------
module fpsqrt_cell (
    input  logic                   clk,
    input  fpsqrt_pkg::cell_ctrl_t ctrl,
    input  logic                   q,
    input  logic [1:0]             load_digit,
    input  logic [1:0]             digit_in,
    input  logic                   rem4_bit,
    input  logic                   trial_bit,
    input  logic                   root_in,
    input  logic                   borrow_in,
    output logic                   rem_bit,
    output logic                   root_bit,
    output logic [1:0]             digit,
    output logic                   borrow_out
);

    logic       rem_reg;
    logic       rem_next;
    logic       root_reg;
    logic [1:0] digit_reg;
    logic       diff;

    assign diff       = rem4_bit ^ trial_bit ^ borrow_in;
    assign borrow_out = (~rem4_bit & trial_bit) | (~(rem4_bit ^ trial_bit) & borrow_in);

    // Keep the difference only when the whole row produced no borrow.
    assign rem_next = q ? diff : rem4_bit;

    always_ff @(posedge clk)
    begin
        if (ctrl.load)
        begin
            rem_reg   <= 1'b0;
            root_reg  <= 1'b0;
            digit_reg <= load_digit;
        end
        else if (ctrl.step)
        begin
            rem_reg   <= rem_next;
            root_reg  <= root_in;
            digit_reg <= digit_in;
        end
    end

    assign rem_bit  = rem_reg;
    assign root_bit = root_reg;
    assign digit    = digit_reg;

endmodule

// ===== hdl/fpsqrt_ctrl.sv =====
// ----------------------------------------------------------------------------
// Square root sequencer
// Loads the cell row on an accepted word, steps it once per root bit and
// raises done for one cycle when the last bit has settled.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module fpsqrt_ctrl #(
    parameter int ROOT_BITS = fpsqrt_pkg::ROOT_INT_W + fpsqrt_pkg::FRAC_BITS_DEF
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   start,
    output logic                   busy,
    output logic                   done,
    output fpsqrt_pkg::cell_ctrl_t ctrl
);

    localparam int               CNT_W = $clog2(ROOT_BITS);
    localparam logic [CNT_W-1:0] LAST  = CNT_W'(ROOT_BITS - 1);

    fpsqrt_pkg::sqrt_state_t state_reg;
    fpsqrt_pkg::sqrt_state_t state_next;
    logic [CNT_W-1:0]        cnt_reg;
    logic [CNT_W-1:0]        cnt_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= fpsqrt_pkg::ST_IDLE;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        unique case (state_reg)
            fpsqrt_pkg::ST_IDLE,
            fpsqrt_pkg::ST_DONE:
            begin
                if (start)
                begin
                    state_next = fpsqrt_pkg::ST_RUN;
                    cnt_next   = '0;
                end
                else
                begin
                    state_next = fpsqrt_pkg::ST_IDLE;
                end
            end
            fpsqrt_pkg::ST_RUN:
            begin
                cnt_next = cnt_reg + CNT_W'(1);
                if (cnt_reg == LAST)
                begin
                    state_next = fpsqrt_pkg::ST_DONE;
                end
            end
            default:
            begin
                state_next = fpsqrt_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        busy      = 1'b0;
        done      = 1'b0;
        ctrl.step = 1'b0;
        unique case (state_reg)
            fpsqrt_pkg::ST_IDLE: ;
            fpsqrt_pkg::ST_RUN:
            begin
                busy      = 1'b1;
                ctrl.step = 1'b1;
            end
            fpsqrt_pkg::ST_DONE:
            begin
                done = 1'b1;
            end
            default: ;
        endcase
        ctrl.load = start && !busy;
    end

    `ASSERT_CLK(a_accept_starts_run, start && !busy |=> busy && cnt_reg == '0, "no run")
    `ASSERT_CLK(a_done_after_last_bit, done |-> $past(busy) && $past(cnt_reg) == LAST, "short run")
    `ASSERT_NEVER(a_load_during_step, ctrl.load && ctrl.step, "cell row loaded while stepping")

endmodule

// ===== hdl/fixed_point_square_root.sv =====
// The result strobes on done once the cell row has settled all ROOT_BITS root bits,
// ROOT_BITS = 32 + FRAC_BITS. A new word is taken only after the last one is through;
// it may start while done is high. The cell row settles one root bit per clock.
// Reset clears the sequencer only: busy and done go low; the result ports are
// meaningful only while done is high, and the receiver cannot stall them.
// ----------------------------------------------------------------------------
// Fixed-point square root
// Digit-by-digit square root of a 63-bit radicand scaled by 4^FRAC_BITS, built
// as a row of bit cells that shift the remainder, root and radicand digits.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module fixed_point_square_root #(
    parameter int FRAC_BITS = fpsqrt_pkg::FRAC_BITS_DEF
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                start,
    output logic                                busy,
    input  logic [fpsqrt_pkg::RADICAND_W-1:0]   radicand,
    output logic                                done,
    output logic [fpsqrt_pkg::ROOT_INT_W-1:0]   root_integer,
    output logic [fpsqrt_pkg::FRAC_FIELD_W-1:0] root_fraction
);

    localparam int RW = fpsqrt_pkg::ROOT_INT_W + FRAC_BITS;
    localparam int FW = fpsqrt_pkg::FRAC_FIELD_W;
    // The remainder stays below 2 * root + 1, so two guard cells above the
    // root plus one for the shifted compare are enough.
    localparam int N  = RW + 3;
    localparam logic [FW-1:0] FRAC_MASK =
        (FRAC_BITS >= FW) ? {FW{1'b1}} : FW'((64'd1 << FRAC_BITS) - 64'd1);

    fpsqrt_pkg::cell_ctrl_t ctrl;
    logic                   q;
    logic [2*RW-1:0]        padded;
    logic [N-1:0]           rem_vec;
    logic [N-1:0]           root_vec;
    logic [N-1:0]           borrow_vec;
    logic [1:0]             digit_vec [N];
    logic [1:0]             top_digit;

    fpsqrt_ctrl #(
        .ROOT_BITS (RW)
    ) u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .busy  (busy),
        .done  (done),
        .ctrl  (ctrl)
    );

    assign padded    = (2*RW)'(radicand) << (2*FRAC_BITS);
    assign top_digit = digit_vec[N-1];
    assign q         = ~borrow_vec[N-1];

    for (genvar i = 0; i < N; i++)
    begin : g_cell
        logic [1:0] load_digit;
        logic [1:0] digit_in;
        logic       rem4_bit;
        logic       trial_bit;
        logic       root_in;
        logic       borrow_in;

        if (i >= 3)
        begin : g_ld
            assign load_digit = padded[2*(i-3) +: 2];
        end
        else
        begin : g_ld0
            assign load_digit = 2'b00;
        end

        if (i >= 2)
        begin : g_hi
            assign rem4_bit  = rem_vec[i-2];
            assign trial_bit = root_vec[i-2];
        end
        else
        begin : g_lo
            assign rem4_bit  = top_digit[i];
            assign trial_bit = (i == 0);
        end

        if (i >= 1)
        begin : g_chain
            assign root_in   = root_vec[i-1];
            assign digit_in  = digit_vec[i-1];
            assign borrow_in = borrow_vec[i-1];
        end
        else
        begin : g_first
            assign root_in   = q;
            assign digit_in  = 2'b00;
            assign borrow_in = 1'b0;
        end

        fpsqrt_cell u_cell (
            .clk        (clk),
            .ctrl       (ctrl),
            .q          (q),
            .load_digit (load_digit),
            .digit_in   (digit_in),
            .rem4_bit   (rem4_bit),
            .trial_bit  (trial_bit),
            .root_in    (root_in),
            .borrow_in  (borrow_in),
            .rem_bit    (rem_vec[i]),
            .root_bit   (root_vec[i]),
            .digit      (digit_vec[i]),
            .borrow_out (borrow_vec[i])
        );
    end

    assign root_integer  = root_vec[RW-1 -: fpsqrt_pkg::ROOT_INT_W];
    assign root_fraction = root_vec[FW-1:0] & FRAC_MASK;

    `ASSERT_CLK(a_root_in_range, done |-> root_integer <= 32'd3037000499, "root out of range")
    `ASSERT_CLK(a_guard_bits_clear, done |-> rem_vec[N-1:N-2] == '0 && root_vec[N-1:RW] == '0, "guard set")

endmodule

// ===== tb/tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Fixed-point square root testbench
// Drives radicand words through the start/busy handshake and checks each
// done strobe against a bit-exact root computed here by trial squaring.
// ----------------------------------------------------------------------------
module tb;

    localparam int RADICAND_W   = fpsqrt_pkg::RADICAND_W;
    localparam int ROOT_INT_W   = fpsqrt_pkg::ROOT_INT_W;
    localparam int FRAC_FIELD_W = fpsqrt_pkg::FRAC_FIELD_W;
    localparam int FRAC_BITS    = fpsqrt_pkg::FRAC_BITS_DEF;
    localparam int ROOT_LATENCY = ROOT_INT_W + FRAC_BITS + 1;
    localparam int CYCLE_LIMIT  = 1000000;
    localparam int PRINT_LIMIT  = 40;

    localparam logic [RADICAND_W-1:0] RADICAND_MAX = {RADICAND_W{1'b1}};
    localparam logic [31:0]           ROOT_OF_MAX  = 32'd3037000499;

    typedef struct {
        logic [RADICAND_W-1:0]   value;
        logic [ROOT_INT_W-1:0]   whole;
        logic [FRAC_FIELD_W-1:0] frac;
    } root_word_t;

    logic                    clk;
    logic                    rst_n;
    logic                    start;
    logic                    busy;
    logic [RADICAND_W-1:0]   radicand;
    logic                    done;
    logic [ROOT_INT_W-1:0]   root_integer;
    logic [FRAC_FIELD_W-1:0] root_fraction;

    root_word_t  pending_roots[$];
    int unsigned mismatches;
    int unsigned words_sent;
    int unsigned roots_checked;
    int unsigned cycle_count = 0;

    fixed_point_square_root dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .start         (start),
        .busy          (busy),
        .radicand      (radicand),
        .done          (done),
        .root_integer  (root_integer),
        .root_fraction (root_fraction)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("Regression FAIL");
            $finish;
        end
    end

    // floor(sqrt(n) * 2^FRAC_BITS) is the integer root of n * 4^FRAC_BITS.
    function automatic root_word_t compute_root(input logic [RADICAND_W-1:0] n);
        logic [127:0] scaled;
        logic [127:0] acc;
        logic [127:0] trial;
        root_word_t   r;
        int           i;
        scaled = 128'(n) << (2 * FRAC_BITS);
        acc = '0;
        for (i = 31 + FRAC_BITS; i >= 0; i--)
        begin
            trial = acc | (128'd1 << i);
            if (trial * trial <= scaled)
                acc = trial;
        end
        r.value = n;
        r.whole = ROOT_INT_W'(acc >> FRAC_BITS);
        r.frac  = FRAC_FIELD_W'(acc & ((128'd1 << FRAC_BITS) - 1));
        return r;
    endfunction

    task automatic report_mismatch(input string what, input logic [RADICAND_W-1:0] n,
                                   input logic [63:0] want, input logic [63:0] got);
        mismatches++;
        if (mismatches <= PRINT_LIMIT)
            $display("MISMATCH %s: radicand %0d expected %0d got %0d", what, n, want, got);
    endtask

    // Mostly short gaps, a few long enough to let the unit go idle.
    function automatic int unsigned pick_gap();
        int unsigned r;
        r = $urandom_range(0, 31);
        if (r < 16)
            return 0;
        else if (r < 29)
            return $urandom_range(1, 4);
        else if (r < 31)
            return $urandom_range(5, 60);
        return $urandom_range(60, 150);
    endfunction

    function automatic logic [RADICAND_W-1:0] random_radicand(input int unsigned bits);
        logic [63:0] v;
        v = {$urandom, $urandom};
        if (bits < 64)
            v = v & ((64'd1 << bits) - 1);
        return RADICAND_W'(v);
    endfunction

    task automatic send_word(input logic [RADICAND_W-1:0] value, input bit with_gap);
        bit          taken;
        int unsigned gap;
        start    <= 1'b1;
        radicand <= value;
        do
        begin
            @(negedge clk);
            taken = !busy;
            @(posedge clk);
        end
        while (!taken);
        pending_roots.push_back(compute_root(value));
        words_sent++;
        gap = with_gap ? pick_gap() : 0;
        if (gap != 0)
        begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    task automatic wait_drain();
        start <= 1'b0;
        while (pending_roots.size() != 0)
            @(posedge clk);
    endtask

    always @(negedge clk)
    begin : check_results
        root_word_t want;
        if (rst_n && done)
        begin
            if (pending_roots.size() == 0)
                report_mismatch("unexpected word", '0, 64'd0, 64'(root_integer));
            else
            begin
                want = pending_roots.pop_front();
                roots_checked++;
                if (root_integer !== want.whole)
                    report_mismatch("root_integer", want.value, 64'(want.whole),
                                    64'(root_integer));
                if (root_fraction !== want.frac)
                    report_mismatch("root_fraction", want.value, 64'(want.frac),
                                    64'(root_fraction));
            end
        end
    end

    task automatic test_edge_values();
        logic [RADICAND_W-1:0] edges[$];
        edges = {0, 1, 2, 3, 4, 5, 8, 99, 63'd1000000000000000000,
                 63'd4294967295, 63'd4294967296, 63'd4294836225, 63'd4294967295 + 63'd1,
                 63'h4000_0000_0000_0000, 63'h3FFF_FFFF_FFFF_FFFF,
                 63'h5555_5555_5555_5555, 63'h2AAA_AAAA_AAAA_AAAA,
                 63'd9223372030926249001, 63'd9223372030926249000, RADICAND_MAX};
        foreach (edges[i])
            send_word(edges[i], 1'b1);
    endtask

    // Words right before, at and after perfect squares push the fraction to its ends.
    task automatic test_near_squares(input int unsigned count);
        logic [63:0] k;
        logic [63:0] n;
        int unsigned off;
        repeat (count)
        begin
            if ($urandom_range(0, 3) == 0)
                k = $urandom_range(0, 300);
            else
                k = $urandom_range(0, ROOT_OF_MAX);
            off = $urandom_range(0, 2);
            n = k * k;
            if (off == 0 && n != 0)
                n = n - 1;
            else if (off == 2)
                n = n + 1;
            if (n > 64'(RADICAND_MAX))
                n = 64'(RADICAND_MAX);
            send_word(RADICAND_W'(n), 1'b1);
        end
    endtask

    task automatic test_random_widths(input int unsigned count);
        int unsigned bits;
        repeat (count)
        begin
            bits = ($urandom_range(0, 1) == 0) ? 63 : $urandom_range(0, 63);
            send_word(random_radicand(bits), 1'b1);
            if ($urandom_range(0, 149) == 0)
                wait_drain();
        end
    endtask

    task automatic test_back_to_back(input int unsigned count);
        repeat (count)
            send_word(random_radicand(63), 1'b0);
    endtask

    // The unit must restart cleanly after it has gone fully idle.
    task automatic test_drain_pause();
        repeat (10)
            send_word(random_radicand(63), 1'b1);
        wait_drain();
        repeat (10)
            send_word(random_radicand($urandom_range(1, 63)), 1'b0);
        wait_drain();
    endtask

    initial
    begin
        clk           = 1'b0;
        rst_n         = 1'b0;
        start         = 1'b0;
        radicand      = '0;
        mismatches    = 0;
        words_sent    = 0;
        roots_checked = 0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_edge_values();
        test_drain_pause();
        test_back_to_back(100);
        test_near_squares(380);
        test_random_widths(700);

        wait_drain();
        repeat (2 * ROOT_LATENCY) @(posedge clk);
        while (pending_roots.size() != 0)
        begin
            report_mismatch("missing word", pending_roots[0].value,
                            64'(pending_roots[0].whole), 64'd0);
            void'(pending_roots.pop_front());
        end

        $display("Sent %0d radicand words, checked %0d roots (%0d fraction bits).",
                 words_sent, roots_checked, FRAC_BITS);
        $display("Covered edge values, near-square words, mixed widths and back-to-back starts.");
        if (mismatches == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule

// ===== fixed_point_square_root.f =====
+incdir+hdl
hdl/fpsqrt_pkg.sv
hdl/fpsqrt_cell.sv
hdl/fpsqrt_ctrl.sv
hdl/fixed_point_square_root.sv
tb/tb.sv
